// ===== src/glsnap_pkg.sv =====
// ----------------------------------------------------------------------------
// glsnap_pkg
// shared codes and the item token that walks the cell row
// ----------------------------------------------------------------------------
package glsnap_pkg;

  localparam int POS_W = 32;
  localparam int TOL_W = 31;

  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic                    vld;
    logic [1:0]              kind;
    logic signed [POS_W-1:0] value;
    logic signed [POS_W-1:0] carry;
    logic                    dup;
    logic                    full;
    logic                    placed;
    logic                    found;
    logic [POS_W-1:0]        best_d;
    logic signed [POS_W-1:0] best_pos;
  } tkn_t;

endpackage

// ===== src/grid_line_table_nearest_snap_unit.sv =====
// ----------------------------------------------------------------------------
// grid_line_table_nearest_snap_unit
// sorted grid-line table with nearest-line snapping
// ----------------------------------------------------------------------------
// The table is a row of MAX_LINES cells, one stored position each. Every item
// travels down the row as a token, one cell per cycle: an insert swaps itself
// into place and shifts the larger entries on, a query keeps the nearest line
// within snap_tolerance (lower index wins ties). A new item is taken only
// once the previous result has moved to the output register, so only one
// item is in flight and a stalled output holds off the next. No clearing pass
// is needed after reset; only entries below the count are used.
module grid_line_table_nearest_snap_unit import glsnap_pkg::*; #(
  parameter int MAX_LINES = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_kind,
  input  logic signed [POS_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_status,
  output logic                    out_found,
  output logic [5:0]              out_line_index,
  output logic signed [POS_W-1:0] out_snapped_position,
  output logic [6:0]              out_entry_count,
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [2:0]              cfg_paddr,
  input  logic [31:0]             cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);

  localparam int IW = $clog2(MAX_LINES);
  localparam int CW = $clog2(MAX_LINES + 1);

  logic [TOL_W-1:0] tol_r;
  logic [CW-1:0]    count_r, count_nxt;
  logic             busy_r;
  logic             fin_vld_r;
  tkn_t             fin_r;
  logic [IW-1:0]    fin_idx_r;
  logic [CW-1:0]    fin_cnt_r;

  logic                    out_valid_r;
  logic [1:0]              out_status_r;
  logic                    out_found_r;
  logic [5:0]              out_line_index_r;
  logic signed [POS_W-1:0] out_pos_r;
  logic [6:0]              out_count_r;

  tkn_t          tkn [MAX_LINES+1];
  logic [IW-1:0] idx [MAX_LINES+1];
  logic [MAX_LINES-1:0] tkn_vld;

  logic          in_accept;
  logic          out_load;
  logic [1:0]    fin_status;
  logic [IW+5:0] idx_ext;
  logic [CW+6:0] cnt_ext;

  assign in_accept = in_valid && !busy_r;
  assign in_stall  = busy_r;

  always_comb begin
    tkn[0]       = '0;
    tkn[0].vld   = in_accept;
    tkn[0].kind  = in_kind;
    tkn[0].value = in_value;
    tkn[0].carry = in_value;
    tkn[0].full  = count_r == CW'(MAX_LINES);
    idx[0]       = '0;
  end

  for (genvar i = 0; i < MAX_LINES; i++) begin : g_cell
    glsnap_cell #(
      .IW       (IW),
      .CELL_IDX (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tol     (tol_r),
      .live    (count_r > CW'(i)),
      .tkn_in  (tkn[i]),
      .idx_in  (idx[i]),
      .tkn_out (tkn[i+1]),
      .idx_out (idx[i+1])
    );
    assign tkn_vld[i] = tkn[i+1].vld;
  end

  always_comb begin
    count_nxt = count_r;
    case (tkn[MAX_LINES].kind)
      KIND_CLEAR:  count_nxt = '0;
      KIND_INSERT: begin
        if (!tkn[MAX_LINES].dup && !tkn[MAX_LINES].full) begin
          count_nxt = count_r + CW'(1);
        end
      end
      default: ;
    endcase
  end

  assign out_load = fin_vld_r && (!out_valid_r || !out_stall);

  always_comb begin
    fin_status = ST_DONE;
    if (fin_r.kind == KIND_INSERT) begin
      if (fin_r.dup) begin
        fin_status = ST_DUP;
      end else if (fin_r.full) begin
        fin_status = ST_FULL;
      end
    end
    idx_ext = {6'b0, fin_idx_r};
    cnt_ext = {7'b0, fin_cnt_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r       <= '0;
      count_r     <= '0;
      busy_r      <= 1'b0;
      fin_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == 3'd0)) begin
        tol_r <= cfg_pwdata[TOL_W-1:0];
      end
      if (in_accept) begin
        busy_r <= 1'b1;
      end else if (out_load) begin
        busy_r <= 1'b0;
      end
      if (tkn[MAX_LINES].vld) begin
        count_r   <= count_nxt;
        fin_vld_r <= 1'b1;
      end else if (out_load) begin
        fin_vld_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tkn[MAX_LINES].vld) begin
      fin_r     <= tkn[MAX_LINES];
      fin_idx_r <= idx[MAX_LINES];
      fin_cnt_r <= count_nxt;
    end
    if (out_load) begin
      out_status_r     <= fin_status;
      out_found_r      <= fin_r.found;
      out_line_index_r <= idx_ext[5:0];
      out_pos_r        <= fin_r.best_pos;
      out_count_r      <= cnt_ext[6:0];
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_found            = out_found_r;
  assign out_line_index       = out_line_index_r;
  assign out_snapped_position = out_pos_r;
  assign out_entry_count      = out_count_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 3'd0) ? {1'b0, tol_r} : 32'd0;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_LINES))
    else $error("entry count above table size");

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({tkn_vld, fin_vld_r}))
    else $error("more than one item in flight");

  a_fin_busy: assert property (@(posedge clk) disable iff (!rst_n)
    fin_vld_r |-> busy_r)
    else $error("finished item pending while not busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> busy_r && !out_load)
    else $error("item accepted but block not busy");

endmodule

// ===== src/glsnap_cell.sv =====
// ----------------------------------------------------------------------------
// glsnap_cell
// one table entry; updates the passing token and hands it to the next cell
// ----------------------------------------------------------------------------
module glsnap_cell import glsnap_pkg::*; #(
  parameter int IW       = 6,
  parameter int CELL_IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [TOL_W-1:0] tol,
  input  logic             live,
  input  tkn_t             tkn_in,
  input  logic [IW-1:0]    idx_in,
  output tkn_t             tkn_out,
  output logic [IW-1:0]    idx_out
);

  logic signed [POS_W-1:0] pos_r, pos_nxt;
  tkn_t                    tkn_r, tkn_nxt;
  logic [IW-1:0]           idx_r, idx_nxt;

  logic [POS_W:0]   diff;
  logic [POS_W:0]   neg;
  logic [POS_W-1:0] mag;
  logic             near;
  logic             better;

  always_comb begin
    diff   = {pos_r[POS_W-1], pos_r} - {tkn_in.value[POS_W-1], tkn_in.value};
    neg    = (POS_W+1)'(0) - diff;
    mag    = diff[POS_W] ? neg[POS_W-1:0] : diff[POS_W-1:0];
    near   = mag <= {1'b0, tol};
    better = !tkn_in.found || (mag < tkn_in.best_d);
  end

  always_comb begin
    pos_nxt = pos_r;
    tkn_nxt = tkn_in;
    idx_nxt = idx_in;
    if (tkn_in.vld) begin
      case (tkn_in.kind)
        KIND_INSERT: begin
          if (live) begin
            if (!tkn_in.dup) begin
              if (pos_r == tkn_in.carry) begin
                tkn_nxt.dup = 1'b1;
              end else if (!tkn_in.full && ($signed(pos_r) > $signed(tkn_in.carry))) begin
                pos_nxt       = tkn_in.carry;
                tkn_nxt.carry = pos_r;
              end
            end
          end else if (!tkn_in.dup && !tkn_in.full && !tkn_in.placed) begin
            pos_nxt        = tkn_in.carry;
            tkn_nxt.placed = 1'b1;
          end
        end
        KIND_QUERY: begin
          if (live && near && better) begin
            tkn_nxt.found    = 1'b1;
            tkn_nxt.best_d   = mag;
            tkn_nxt.best_pos = pos_r;
            idx_nxt          = IW'(CELL_IDX);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tkn_r <= '0;
    end else begin
      tkn_r <= tkn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    idx_r <= idx_nxt;
  end

  assign tkn_out = tkn_r;
  assign idx_out = idx_r;

endmodule

// ===== test/tb_grid_line_table_nearest_snap_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_line_table_nearest_snap_unit
// Self-checking bench for the sorted grid-line table with nearest-line snap.
// A scoreboard keeps its own copy of the table and the tolerance. It works out
// each result when an item is accepted, and compares every delivered result
// field by field, in order. Stimulus is a directed opening, then random phases.
// Each phase either fills the table to overflow or mixes every operation.
// Random idling runs on both channels, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_grid_line_table_nearest_snap_unit;
  import glsnap_pkg::*;

  localparam int LINES = 64;
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam logic [2:0] ADDR_SNAP_TOL = 3'd0;
  localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] POS_MAX = 32'sh7fff_ffff;
  localparam logic [30:0] TOL_MAX = 31'h7fff_ffff;
  localparam int DRAIN_CYCLES = LINES + 16;
  localparam int RANDOM_ITEMS = 900;
  localparam int HOLD_AT_RESULT = 150;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic [5:0]         line_index;
    logic signed [31:0] snapped_position;
    logic [6:0]         entry_count;
  } snap_result_t;

  class snap_scoreboard;
    logic signed [31:0] lines [LINES];
    int count;
    logic [30:0] tol;
    snap_result_t expected_snaps[$];
    int errors;

    function new();
      count = 0;
      tol = '0;
      errors = 0;
    endfunction

    function void set_tol(logic [30:0] t);
      tol = t;
    endfunction

    function int pending();
      return expected_snaps.size();
    endfunction

    function void note_item(logic [1:0] kind, logic signed [31:0] v);
      snap_result_t r;
      int p;
      int k;
      logic signed [32:0] diff;
      logic [32:0] mag;
      logic [32:0] best;
      r = '0;
      best = '0;
      case (kind)
        KIND_CLEAR: count = 0;
        KIND_INSERT: begin
          p = 0;
          while (p < count && lines[p] < v) p++;
          if (p < count && lines[p] == v) begin
            r.status = ST_DUP;
          end else if (count >= LINES) begin
            r.status = ST_FULL;
          end else begin
            for (k = count; k > p; k--) lines[k] = lines[k-1];
            lines[p] = v;
            count++;
          end
        end
        KIND_QUERY: begin
          for (k = 0; k < count; k++) begin
            diff = {lines[k][31], lines[k]} - {v[31], v};
            if (diff < 0) mag = -diff;
            else mag = diff;
            if (mag <= {2'b00, tol} && (!r.found || mag < best)) begin
              best = mag;
              r.found = 1'b1;
              r.line_index = 6'(k);
              r.snapped_position = lines[k];
            end
          end
        end
        default: ;
      endcase
      r.entry_count = 7'(count);
      expected_snaps.insert(expected_snaps.size(), r);
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
    endfunction

    function void check_item(snap_result_t got);
      snap_result_t want;
      if (expected_snaps.size() == 0) begin
        errors++;
        $display("%0t: result with no item pending, actual %0h", $time, got);
        return;
      end
      want = expected_snaps.pop_front();
      if (got.status !== want.status) report("status", want.status, got.status);
      if (got.found !== want.found) report("found", want.found, got.found);
      if (got.line_index !== want.line_index)
        report("line_index", want.line_index, got.line_index);
      if (got.snapped_position !== want.snapped_position)
        report("snapped_position", want.snapped_position, got.snapped_position);
      if (got.entry_count !== want.entry_count)
        report("entry_count", want.entry_count, got.entry_count);
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [1:0]              in_kind;
  logic signed [POS_W-1:0] in_value;
  logic                    out_valid;
  logic                    out_stall;
  logic [1:0]              out_status;
  logic                    out_found;
  logic [5:0]              out_line_index;
  logic signed [POS_W-1:0] out_snapped_position;
  logic [6:0]              out_entry_count;
  logic                    cfg_psel;
  logic                    cfg_penable;
  logic                    cfg_pwrite;
  logic [2:0]              cfg_paddr;
  logic [31:0]             cfg_pwdata;
  logic [31:0]             cfg_prdata;
  logic                    cfg_pready;

  snap_scoreboard sb;
  bit no_idle;
  int items_sent;

  grid_line_table_nearest_snap_unit #(.MAX_LINES(LINES)) uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_kind              (in_kind),
    .in_value             (in_value),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_found            (out_found),
    .out_line_index       (out_line_index),
    .out_snapped_position (out_snapped_position),
    .out_entry_count      (out_entry_count),
    .cfg_psel             (cfg_psel),
    .cfg_penable          (cfg_penable),
    .cfg_pwrite           (cfg_pwrite),
    .cfg_paddr            (cfg_paddr),
    .cfg_pwdata           (cfg_pwdata),
    .cfg_prdata           (cfg_prdata),
    .cfg_pready           (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int idle_draw();
    if (no_idle) return 0;
    return $urandom_range(0, 6);
  endfunction

  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] base;
    case ($urandom_range(0, 6))
      0: return $urandom;
      1: return 32'($urandom_range(0, 400)) - 200;
      2: begin
        case ($urandom_range(0, 3))
          0: return POS_MIN;
          1: return POS_MAX;
          2: return 0;
          default: return -1;
        endcase
      end
      default: begin
        if (sb.count == 0) return $urandom;
        base = sb.lines[$urandom_range(0, sb.count - 1)];
        case ($urandom_range(0, 4))
          0: return base + {1'b0, sb.tol};
          1: return base - {1'b0, sb.tol};
          2: return base + {1'b0, sb.tol} + 1;
          3: return base - {1'b0, sb.tol} - 1;
          default: return base + 32'($urandom_range(0, 40)) - 20;
        endcase
      end
    endcase
  endfunction

  function automatic logic [30:0] pick_tol();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return TOL_MAX;
      2: return 31'd1;
      3: return 31'($urandom_range(0, 64));
      4: return 31'($urandom_range(0, 5000));
      default: return 31'($urandom >> 1);
    endcase
  endfunction

  // valid stays high between back-to-back items
  task automatic send_item(input logic [1:0] kind, input logic signed [31:0] value);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_value <= value;
    do @(posedge clk); while (in_stall);
    sb.note_item(kind, value);
    items_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_tol(input logic [31:0] data);
    settle();
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_SNAP_TOL;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    sb.set_tol(data[30:0]);
  endtask

  // clear, overfill, then duplicates into the full table, then queries
  task automatic run_fill_phase();
    int n;
    int i;
    send_item(KIND_CLEAR, $urandom);
    n = LINES + $urandom_range(1, 4);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 1)) send_item(KIND_INSERT, $urandom);
      else send_item(KIND_INSERT, 32'($urandom_range(0, 20000)) - 10000);
    end
    for (i = 0; i < 3; i++)
      send_item(KIND_INSERT, sb.lines[$urandom_range(0, sb.count - 1)]);
    for (i = 0; i < 12; i++) send_item(KIND_QUERY, pick_value());
  endtask

  task automatic run_mixed_phase(input int n);
    int i;
    int r;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3) send_item(KIND_CLEAR, $urandom);
      else if (r < 6) send_item(KIND_SPARE, $urandom);
      else if (r < 42) send_item(KIND_INSERT, pick_value());
      else send_item(KIND_QUERY, pick_value());
    end
  endtask

  initial begin
    int results_seen;
    int gap;
    bit held_long;
    snap_result_t got;
    results_seen = 0;
    held_long = 0;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!held_long && results_seen == HOLD_AT_RESULT) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        held_long = 1;
      end
      gap = idle_draw();
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      got.status = out_status;
      got.found = out_found;
      got.line_index = out_line_index;
      got.snapped_position = out_snapped_position;
      got.entry_count = out_entry_count;
      sb.check_item(got);
      results_seen++;
    end
  end

  initial begin
    sb = new();
    no_idle = 0;
    items_sent = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_kind <= KIND_CLEAR;
    in_value <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // top data bit is not part of the register
    write_tol(32'h8000_0000);
    send_item(KIND_QUERY, 0);
    send_item(KIND_SPARE, 32'h5a5a_5a5a);
    send_item(KIND_INSERT, 0);
    send_item(KIND_INSERT, POS_MIN);
    send_item(KIND_INSERT, POS_MAX);
    send_item(KIND_INSERT, 0);
    send_item(KIND_INSERT, 100);
    send_item(KIND_INSERT, -100);
    send_item(KIND_QUERY, POS_MAX);
    send_item(KIND_QUERY, POS_MIN);
    send_item(KIND_QUERY, 1);
    send_item(KIND_QUERY, -100);
    write_tol({1'b0, TOL_MAX});
    send_item(KIND_QUERY, 50);
    send_item(KIND_QUERY, -50);
    send_item(KIND_QUERY, 0);
    send_item(KIND_SPARE, -1);
    send_item(KIND_CLEAR, 0);
    send_item(KIND_QUERY, 7);
    send_item(KIND_INSERT, POS_MIN);
    send_item(KIND_QUERY, POS_MAX);
    send_item(KIND_INSERT, POS_MAX);
    send_item(KIND_QUERY, -1);
    write_tol(32'd1);
    send_item(KIND_QUERY, POS_MAX - 1);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      write_tol({1'($urandom_range(0, 1)), pick_tol()});
      if ($urandom_range(0, 2) == 0) run_fill_phase();
      else run_mixed_phase($urandom_range(30, 70));
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
